>>> sv/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, field widths and codes for the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int OP_W     = 3;
    localparam int PAGE_W   = 14;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 15;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [PAGE_W-1:0]   page_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam op_t OP_INIT   = 3'd0;
    localparam op_t OP_ALLOC  = 3'd1;
    localparam op_t OP_FREE   = 3'd2;
    localparam op_t OP_INCREF = 3'd3;
    localparam op_t OP_DECREF = 3'd4;

    localparam status_t ST_OK     = 3'd0;
    localparam status_t ST_NOFREE = 3'd1;
    localparam status_t ST_RANGE  = 3'd2;
    localparam status_t ST_NOINIT = 3'd3;
    localparam status_t ST_COUNT  = 3'd4;

    localparam logic [CFG_W-1:0] TOTAL_PAGES_RESET    = 15'd16384;
    localparam logic [CFG_W-1:0] RESERVED_PAGES_RESET = 15'd0;

    localparam count_t COUNT_MAX = 16'hFFFF;

    // register indexes on the configuration port
    localparam logic REG_TOTAL_PAGES    = 1'b0;
    localparam logic REG_RESERVED_PAGES = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] total_pages;
        logic [CFG_W-1:0] reserved_pages;
    } cfg_t;

    // one entry of the per-page memory
    typedef struct packed {
        count_t count;
        logic   on_free;
    } page_entry_t;

endpackage

>>> sv/pfa_cmd_if.sv
// ----------------------------------------------------------------------------
// pfa_cmd_if
// Command channel: one operation word per handshake.
// ----------------------------------------------------------------------------
interface pfa_cmd_if;
    import pfa_pkg::*;

    logic  valid;
    logic  ready;
    op_t   op;
    page_t page_index;

    modport source (output valid, output op, output page_index, input ready);
    modport sink   (input valid, input op, input page_index, output ready);

endinterface

>>> sv/pfa_rsp_if.sv
// ----------------------------------------------------------------------------
// pfa_rsp_if
// Response channel: one result word per command.
// ----------------------------------------------------------------------------
interface pfa_rsp_if;
    import pfa_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    page_t   result_page;
    count_t  ref_count;
    logic    freed;

    modport source (output valid, output status, output result_page, output ref_count,
                    output freed, input ready);
    modport sink   (input valid, input status, input result_page, input ref_count,
                    input freed, output ready);

endinterface

>>> sv/page_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_top
// Physical page allocator with per-page reference counts and a LIFO free stack.
// ----------------------------------------------------------------------------
// Free, incref and decref read the page entry, then write it back when it
// changes; a refused alloc and an unknown op pass through the same steps. A
// successful alloc adds a step, as the popped page number read from the stack
// memory addresses a second read of the page memory. Init sweeps the page
// memory one entry a cycle. A result waits in an output register and the block
// finishes its next word only once that register is free. The memories hold no
// defined contents after reset: alloc, free, incref and decref answer
// "not initialized" until the first init, so no clearing pass is run. The
// user must write registers only while the block is idle; nothing enforces it.
module page_frame_allocator_top #(
    parameter int PAGES = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    pfa_cmd_if.sink     cmd,
    pfa_rsp_if.source   rsp
);
    import pfa_pkg::*;

    cfg_t cfg;

    pfa_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pfa_engine #(
        .PAGES (PAGES)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (cmd),
        .rsp   (rsp)
    );

endmodule

>>> sv/pfa_cfg_regs.sv
// ----------------------------------------------------------------------------
// pfa_cfg_regs
// APB-style register file holding total_pages and reserved_pages.
// ----------------------------------------------------------------------------
module pfa_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output pfa_pkg::cfg_t       cfg
);
    import pfa_pkg::*;

    logic [CFG_W-1:0] total_reg;
    logic [CFG_W-1:0] total_next;
    logic [CFG_W-1:0] reserved_reg;
    logic [CFG_W-1:0] reserved_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb
    begin
        total_next    = total_reg;
        reserved_next = reserved_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_TOTAL_PAGES:    total_next    = pwdata[CFG_W-1:0];
                REG_RESERVED_PAGES: reserved_next = pwdata[CFG_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= TOTAL_PAGES_RESET;
            reserved_reg <= RESERVED_PAGES_RESET;
        end
        else
        begin
            total_reg    <= total_next;
            reserved_reg <= reserved_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TOTAL_PAGES:    prdata = {{(32-CFG_W){1'b0}}, total_reg};
            REG_RESERVED_PAGES: prdata = {{(32-CFG_W){1'b0}}, reserved_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.total_pages    = total_reg;
    assign cfg.reserved_pages = reserved_reg;

endmodule

>>> sv/pfa_engine.sv
// ----------------------------------------------------------------------------
// pfa_engine
// Sequencer over the page memory (count, free flag) and the free stack memory.
// ----------------------------------------------------------------------------
module pfa_engine #(
    parameter int PAGES = 16384
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pfa_pkg::cfg_t  cfg,
    pfa_cmd_if.sink        cmd,
    pfa_rsp_if.source      rsp
);
    import pfa_pkg::*;

    localparam int PW = $clog2(PAGES);
    localparam int CW = (PW + 1 > CFG_W) ? PW + 1 : CFG_W;

    localparam logic [CW-1:0] PAGES_C    = CW'(PAGES);
    localparam logic [PW:0]   DEPTH_FULL = (PW+1)'(PAGES);
    localparam logic [PW-1:0] IDX_LAST   = PW'(PAGES - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_INIT  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_ALLOC = 2'd3;

    // memories
    page_entry_t      page_mem [PAGES];
    logic [PW-1:0]    stack_mem [PAGES];
    page_entry_t      pm_rdata_reg;
    logic [PW-1:0]    sm_rdata_reg;

    logic             pm_re;
    logic [PW-1:0]    pm_raddr;
    logic             pm_we;
    logic [PW-1:0]    pm_waddr;
    page_entry_t      pm_wdata;
    logic             sm_re;
    logic             sm_we;
    logic [PW-1:0]    sm_waddr;
    logic [PW-1:0]    sm_wdata;

    // control state
    logic [1:0]       state_reg, state_next;
    logic             init_reg, init_next;
    logic [PW:0]      depth_reg, depth_next;
    logic [PW-1:0]    idx_reg, idx_next;
    op_t              op_reg, op_next;
    page_t            page_reg, page_next;
    logic             out_valid_reg, out_valid_next;

    // result word
    status_t          status_reg, status_next;
    page_t            rpage_reg, rpage_next;
    count_t           count_reg, count_next;
    logic             freed_reg, freed_next;

    // derived values
    logic [CW-1:0]    tp_ext, rs_ext, lim, res, span;
    logic [CW-1:0]    cmd_page_ext, page_ext, idx_ext, idx_off, pop_ext;
    logic [PW:0]      depth_m1;
    logic             out_free, can_push, init_free;
    count_t           c, c_inc, c_dec;
    logic             fb;

    assign tp_ext       = CW'(cfg.total_pages);
    assign rs_ext       = CW'(cfg.reserved_pages);
    assign lim          = (tp_ext > PAGES_C) ? PAGES_C : tp_ext;
    assign res          = (rs_ext > lim) ? lim : rs_ext;
    assign span         = lim - res;
    assign cmd_page_ext = CW'(cmd.page_index);
    assign page_ext     = CW'(page_reg);
    assign idx_ext      = CW'(idx_reg);
    assign idx_off      = idx_ext - res;
    assign pop_ext      = CW'(sm_rdata_reg);
    assign depth_m1     = depth_reg - (PW+1)'(1);
    assign init_free    = (idx_ext >= res) && (idx_ext < lim);
    assign out_free     = !out_valid_reg || rsp.ready;
    assign can_push     = (depth_reg != DEPTH_FULL);
    assign c            = pm_rdata_reg.count;
    assign fb           = pm_rdata_reg.on_free;
    assign c_inc        = c + count_t'(1);
    assign c_dec        = c - count_t'(1);

    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        depth_next     = depth_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        page_next      = page_reg;
        out_valid_next = out_valid_reg & ~rsp.ready;
        status_next    = status_reg;
        rpage_next     = rpage_reg;
        count_next     = count_reg;
        freed_next     = freed_reg;

        pm_re    = 1'b0;
        pm_raddr = cmd_page_ext[PW-1:0];
        pm_we    = 1'b0;
        pm_waddr = page_ext[PW-1:0];
        pm_wdata = pm_rdata_reg;
        sm_re    = 1'b0;
        sm_we    = 1'b0;
        sm_waddr = depth_reg[PW-1:0];
        sm_wdata = page_ext[PW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next   = cmd.op;
                    page_next = cmd.page_index;
                    pm_re     = 1'b1;
                    sm_re     = 1'b1;
                    idx_next  = '0;
                    state_next = (cmd.op == OP_INIT) ? S_INIT : S_EXEC;
                end
            end

            S_INIT:
            begin
                pm_we            = 1'b1;
                pm_waddr         = idx_reg;
                pm_wdata.count   = (idx_ext < res) ? count_t'(1) : '0;
                pm_wdata.on_free = init_free;
                sm_we            = init_free;
                sm_waddr         = idx_off[PW-1:0];
                sm_wdata         = idx_reg;
                idx_next         = idx_reg + PW'(1);
                if (idx_reg == IDX_LAST)
                begin
                    depth_next = span[PW:0];
                    init_next  = 1'b1;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    rpage_next     = page_reg;
                    count_next     = '0;
                    freed_next     = 1'b0;
                    state_next     = S_IDLE;
                    case (op_reg) inside
                        OP_INIT: ;
                        OP_ALLOC:
                        begin
                            if (!init_reg)
                                status_next = ST_NOINIT;
                            else if (depth_reg == '0)
                                status_next = ST_NOFREE;
                            else
                            begin
                                // second read: entry of the popped page
                                out_valid_next = out_valid_reg & ~rsp.ready;
                                depth_next     = depth_m1;
                                pm_re          = 1'b1;
                                pm_raddr       = sm_rdata_reg;
                                state_next     = S_ALLOC;
                            end
                        end
                        OP_FREE, OP_INCREF, OP_DECREF:
                        begin
                            if (!init_reg)
                                status_next = ST_NOINIT;
                            else if (page_ext >= lim)
                                status_next = ST_RANGE;
                            else
                            begin
                                count_next = c;
                                case (op_reg)
                                    OP_FREE:
                                    begin
                                        if (fb)
                                            status_next = ST_COUNT;
                                        else if (c == '0 && can_push)
                                        begin
                                            freed_next       = 1'b1;
                                            pm_we            = 1'b1;
                                            pm_wdata.on_free = 1'b1;
                                            sm_we            = 1'b1;
                                            depth_next       = depth_reg + (PW+1)'(1);
                                        end
                                    end
                                    OP_INCREF:
                                    begin
                                        if (fb || c == COUNT_MAX)
                                            status_next = ST_COUNT;
                                        else
                                        begin
                                            count_next     = c_inc;
                                            pm_we          = 1'b1;
                                            pm_wdata.count = c_inc;
                                        end
                                    end
                                    default:
                                    begin
                                        if (c == '0)
                                            status_next = ST_COUNT;
                                        else
                                        begin
                                            count_next     = c_dec;
                                            pm_we          = 1'b1;
                                            pm_wdata.count = c_dec;
                                            if (c_dec == '0 && !fb && can_push)
                                            begin
                                                freed_next       = 1'b1;
                                                pm_wdata.on_free = 1'b1;
                                                sm_we            = 1'b1;
                                                depth_next       = depth_reg + (PW+1)'(1);
                                            end
                                        end
                                    end
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_ALLOC:
            begin
                if (out_free)
                begin
                    pm_we            = 1'b1;
                    pm_waddr         = sm_rdata_reg;
                    pm_wdata.on_free = 1'b0;
                    out_valid_next   = 1'b1;
                    status_next      = ST_OK;
                    rpage_next       = pop_ext[PAGE_W-1:0];
                    count_next       = c;
                    freed_next       = 1'b0;
                    state_next       = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pm_we)
            page_mem[pm_waddr] <= pm_wdata;
        if (pm_re)
            pm_rdata_reg <= page_mem[pm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
            stack_mem[sm_waddr] <= sm_wdata;
        if (sm_re)
            sm_rdata_reg <= stack_mem[depth_m1[PW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            init_reg      <= 1'b0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        page_reg   <= page_next;
        status_reg <= status_next;
        rpage_reg  <= rpage_next;
        count_reg  <= count_next;
        freed_reg  <= freed_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.result_page = rpage_reg;
    assign rsp.ref_count   = count_reg;
    assign rsp.freed       = freed_reg;

endmodule

>>> bench/pfa_answer_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_answer_check
// Watches the command, response and register ports of the page frame
// allocator. It keeps its own copy of the page counts and the free stack,
// works out the answer to every accepted command word, and compares each
// response word field by field, in order. Register reads are checked too.
// ----------------------------------------------------------------------------
module pfa_answer_check #(
    parameter int PAGES = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    pfa_cmd_if          cmd,
    pfa_rsp_if          rsp,
    output int          outstanding,
    output int          errors,
    output int          compared
);
    import pfa_pkg::*;

    typedef struct packed {
        status_t status;
        page_t   page;
        count_t  count;
        logic    freed;
    } answer_t;

    count_t           page_count [PAGES];
    logic             on_stack   [PAGES];
    page_t            free_pages [PAGES];
    int               free_depth;
    logic             swept;
    logic [CFG_W-1:0] total_pages;
    logic [CFG_W-1:0] reserved_pages;
    answer_t          due_answers [$];

    function automatic int managed_pages();
        return (total_pages > PAGES) ? PAGES : int'(total_pages);
    endfunction

    function automatic logic push_free_page(int pg);
        if (free_depth >= PAGES)
            return 1'b0;
        free_pages[free_depth] = page_t'(pg);
        free_depth++;
        on_stack[pg] = 1'b1;
        return 1'b1;
    endfunction

    function automatic void init_pages();
        int lim;
        int res;
        lim = managed_pages();
        res = (reserved_pages > lim) ? lim : int'(reserved_pages);
        free_depth = 0;
        for (int i = 0; i < PAGES; i++)
        begin
            on_stack[i]   = 1'b0;
            page_count[i] = (i < res) ? count_t'(1) : count_t'(0);
        end
        for (int i = res; i < lim; i++)
            void'(push_free_page(i));
        swept = 1'b1;
    endfunction

    function automatic answer_t allocator_answer(op_t op, page_t pg);
        answer_t a;
        count_t  c;
        page_t   p;
        a.status = ST_OK;
        a.page   = pg;
        a.count  = '0;
        a.freed  = 1'b0;
        if (op == OP_INIT)
            init_pages();
        else if (op <= OP_DECREF)
        begin
            if (!swept)
                a.status = ST_NOINIT;
            else if (op == OP_ALLOC)
            begin
                if (free_depth == 0)
                    a.status = ST_NOFREE;
                else
                begin
                    free_depth--;
                    p = free_pages[free_depth];
                    on_stack[p] = 1'b0;
                    a.page  = p;
                    a.count = page_count[p];
                end
            end
            else if (pg >= managed_pages())
                a.status = ST_RANGE;
            else
            begin
                c = page_count[pg];
                if (op == OP_FREE)
                begin
                    if (on_stack[pg])
                        a.status = ST_COUNT;
                    else if (c == 0 && push_free_page(pg))
                        a.freed = 1'b1;
                end
                else if (op == OP_INCREF)
                begin
                    if (on_stack[pg] || c == COUNT_MAX)
                        a.status = ST_COUNT;
                    else
                        c++;
                end
                else if (c == 0)
                    a.status = ST_COUNT;
                else
                begin
                    c--;
                    if (c == 0 && !on_stack[pg] && push_free_page(pg))
                        a.freed = 1'b1;
                end
                page_count[pg] = c;
                a.count = c;
            end
        end
        return a;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, seen);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t want;
        if (!rst_n)
        begin
            total_pages    = TOTAL_PAGES_RESET;
            reserved_pages = RESERVED_PAGES_RESET;
            free_depth     = 0;
            swept          = 1'b0;
            due_answers.delete();
            outstanding    = 0;
            errors         = 0;
            compared       = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_TOTAL_PAGES)
                        total_pages = pwdata[CFG_W-1:0];
                    else
                        reserved_pages = pwdata[CFG_W-1:0];
                end
                else if (paddr[2] == REG_TOTAL_PAGES)
                    check_field("total_pages read", total_pages, prdata[CFG_W-1:0]);
                else
                    check_field("reserved_pages read", reserved_pages, prdata[CFG_W-1:0]);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (due_answers.size() == 0)
                begin
                    errors++;
                    $display("%0t: response word with none expected: status %0d page %0d",
                             $time, rsp.status, rsp.result_page);
                end
                else
                begin
                    want = due_answers.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("result_page", want.page, rsp.result_page);
                    check_field("ref_count", want.count, rsp.ref_count);
                    check_field("freed", want.freed, rsp.freed);
                    compared++;
                end
            end
            if (cmd.valid && cmd.ready)
                due_answers.push_back(allocator_answer(cmd.op, cmd.page_index));
            outstanding = due_answers.size();
        end
    end

endmodule

>>> bench/tb_page_frame_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_frame_allocator_top
// Drives the page frame allocator with directed and random command words
// under a range of register settings, with random gaps and stalls on both
// channels. Answers are checked by pfa_answer_check beside the block.
// ----------------------------------------------------------------------------
module tb_page_frame_allocator_top;
    import pfa_pkg::*;

    localparam int   PAGES        = 16384;
    localparam int   LIMIT        = 4_000_000;
    localparam int   PHASES       = 8;
    localparam int   PHASE_WORDS  = 160;
    localparam op_t  OP_SPARE_LO  = 3'd5;
    localparam op_t  OP_SPARE_HI  = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        calm;
    int          outstanding;
    int          errors;
    int          compared;
    int          cycles;
    int          words_sent;
    int          inits;
    int          settings;
    int          cur_total;
    int          cur_reserved;

    pfa_cmd_if cmd_ch ();
    pfa_rsp_if rsp_ch ();

    page_frame_allocator_top #(
        .PAGES   (PAGES)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch)
    );

    pfa_answer_check #(
        .PAGES       (PAGES)
    ) i_answer_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cmd         (cmd_ch),
        .rsp         (rsp_ch),
        .outstanding (outstanding),
        .errors      (errors),
        .compared    (compared)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timed out after %0d cycles, %0d words still awaited", cycles, outstanding);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // response stalls
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 36);
        end
    end

    function automatic logic [2:0] reg_addr(logic idx);
        return {idx, 2'b00};
    endfunction

    task automatic send_word(input op_t op, input page_t pg);
        while (!calm && $urandom_range(0, 99) < 36)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.op         <= op;
        cmd_ch.page_index <= pg;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
        if (op == OP_INIT)
            inits++;
    endtask

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input int data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic reconfigure(input int total, input int reserved);
        settle();
        apb_access(1'b1, reg_addr(REG_TOTAL_PAGES), total);
        apb_access(1'b1, reg_addr(REG_RESERVED_PAGES), reserved);
        apb_access(1'b0, reg_addr(REG_TOTAL_PAGES), 0);
        apb_access(1'b0, reg_addr(REG_RESERVED_PAGES), 0);
        cur_total    = total;
        cur_reserved = reserved;
        settings++;
    endtask

    // bias towards pages that allocs hand out and the reserved boundary
    function automatic page_t pick_page();
        int mc;
        int res;
        int r;
        mc  = (cur_total > PAGES) ? PAGES : cur_total;
        res = (cur_reserved > mc) ? mc : cur_reserved;
        r   = $urandom_range(0, 99);
        if (mc == 0 || r >= 85)
            return page_t'($urandom);
        else if (r < 45)
            return page_t'($urandom_range((mc > 32) ? mc - 32 : 0, mc - 1));
        else if (r < 65)
            return page_t'($urandom_range((res > 8) ? res - 8 : 0,
                                          (res + 8 < PAGES) ? res + 8 : PAGES - 1));
        else if (r < 80)
            return page_t'($urandom_range(0, mc - 1));
        else
            return ($urandom_range(0, 1) != 0) ? page_t'(0) : page_t'(PAGES - 1);
    endfunction

    task automatic random_word(output logic counted);
        int  r;
        op_t op;
        r = $urandom_range(0, 999);
        counted = 1'b1;
        if (r < 3)
            op = OP_INIT;
        else if (r < 300)
            op = OP_ALLOC;
        else if (r < 480)
            op = OP_FREE;
        else if (r < 700)
            op = OP_INCREF;
        else if (r < 950)
            op = OP_DECREF;
        else
        begin
            op = op_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            counted = 1'b0;
        end
        send_word(op, pick_page());
    endtask

    initial
    begin
        int   n;
        logic counted;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.op          = OP_INIT;
        cmd_ch.page_index  = '0;
        calm               = 1'b0;
        words_sent         = 0;
        inits              = 0;
        settings           = 0;
        cur_total          = TOTAL_PAGES_RESET;
        cur_reserved       = RESERVED_PAGES_RESET;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // nothing is usable before the first init
        send_word(OP_ALLOC, '0);
        send_word(OP_FREE, '0);
        send_word(OP_INCREF, page_t'(PAGES - 1));
        send_word(OP_DECREF, page_t'(5));
        for (int o = OP_SPARE_LO; o <= OP_SPARE_HI; o++)
            send_word(op_t'(o), pick_page());

        // four pages, page 0 reserved
        reconfigure(4, 1);
        send_word(OP_INIT, '0);
        send_word(OP_ALLOC, '0);
        send_word(OP_ALLOC, '0);
        send_word(OP_ALLOC, '0);
        send_word(OP_ALLOC, page_t'(9));
        send_word(OP_FREE, page_t'(3));
        send_word(OP_FREE, page_t'(3));
        send_word(OP_INCREF, page_t'(3));
        send_word(OP_INCREF, page_t'(0));
        send_word(OP_DECREF, page_t'(0));
        send_word(OP_DECREF, page_t'(0));
        send_word(OP_DECREF, page_t'(0));
        send_word(OP_FREE, page_t'(2));
        send_word(OP_INCREF, page_t'(1));
        send_word(OP_FREE, page_t'(1));
        send_word(OP_FREE, page_t'(4));
        send_word(OP_INCREF, page_t'(PAGES - 1));
        send_word(OP_ALLOC, '0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: reconfigure(PAGES, 0);
                1: reconfigure(1, 0);
                2: reconfigure(32767, 32767);
                3: reconfigure($urandom_range(2, 40), $urandom_range(0, 8));
                4: reconfigure(0, 5);
                5: reconfigure(16, 20);
                6: reconfigure($urandom_range(1, 64), $urandom_range(0, 70));
                default: reconfigure(PAGES - 1, PAGES - 4);
            endcase
            calm = (ph == 3);
            send_word(OP_INIT, pick_page());
            n = 0;
            while (n < PHASE_WORDS)
            begin
                // managed count changes under a live free stack
                if (n == PHASE_WORDS / 2 && $urandom_range(0, 1) != 0)
                    reconfigure($urandom_range(0, 48), cur_reserved);
                random_word(counted);
                if (counted)
                    n++;
            end
            calm = 1'b0;
        end

        settle();
        $display("Sent %0d command words (%0d inits, one phase without gaps) over %0d settings;",
                 words_sent, inits, settings);
        $display("%0d response words compared, %0d mismatches.", compared, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> page_frame_allocator_top.f
sv/pfa_pkg.sv
sv/pfa_cmd_if.sv
sv/pfa_rsp_if.sv
sv/pfa_cfg_regs.sv
sv/pfa_engine.sv
sv/page_frame_allocator_top.sv
bench/pfa_answer_check.sv
bench/tb_page_frame_allocator_top.sv
